// File: hdl/spmf_pkg.sv
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared sizes, codes and types for the strict priority multi-queue.
// ----------------------------------------------------------------------------
package spmf_pkg;

  localparam int NUM_LEVELS = 8;
  localparam int POOL_DEPTH = 64;
  localparam int DATA_WIDTH = 32;

  // node index, pool count and level index widths
  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int LIDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

  // fixed field widths of the ports
  localparam int ACTION_W = 2;
  localparam int LEVEL_W  = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int LCOUNT_W = 7;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LIDX_W-1:0]     lidx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // write request toward the link memory
  typedef struct packed {
    logic en;
    idx_t addr;
    idx_t data;
  } link_wr_t;

endpackage

// File: hdl/strict_priority_multi_fifo.sv
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Priority queues, one per level, sharing one linked pool of nodes.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries an action, a level
//   and a data handle. Actions: enqueue, dequeue, peek, clear of a level.
//   Response channel (out_valid_o / out_ready_i) returns one item per
//   request: head data, status, the level's count afterwards, and the
//   highest-priority nonempty level (level 0 is the highest).
//   Timing: a request is accepted in the idle state, in which the head
//   node's link and payload are read from the synchronous memories; the
//   update state then applies the update and loads the output register.
//   A new request is taken only after that update, since the registered
//   read of the link memory must be seen before a head or free pointer moves.
//   The result is valid once the update loads the output register, later
//   only while an earlier result still sits unread in the output register.
//   Stall: a pending result sits in the output register while the next
//   request is accepted; that request then holds in its update cycle
//   until the output register is taken.
//   Reset: all levels empty, all nodes free and linked in index order;
//   no clearing pass is needed, valid bits on the link memory supply
//   the reset links.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo
  import spmf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [LEVEL_W-1:0]  level_i,
  input  logic [ITEM_W-1:0]   item_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ITEM_W-1:0]   out_data_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [LCOUNT_W-1:0] level_count_o,
  output logic                any_pending_o,
  output logic [LEVEL_W-1:0]  top_level_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  localparam int SUM_W = CNT_W + LIDX_W + 1;

  state_e  state_q, state_d;
  logic    in_fire, exec_go;

  // pool and level bookkeeping
  idx_t    free_head_q, free_head_d;
  cnt_t    free_count_q, free_count_d;
  cnt_t    level_size_q [NUM_LEVELS];
  cnt_t    level_size_d [NUM_LEVELS];
  idx_t    level_head_q [NUM_LEVELS];
  idx_t    level_head_d [NUM_LEVELS];
  idx_t    level_tail_q [NUM_LEVELS];
  idx_t    level_tail_d [NUM_LEVELS];

  // captured request
  action_e action_q;
  logic    lvl_ok_q;
  lidx_t   lidx_q;
  data_t   data_q;

  // incoming decode
  logic        lvl_ok_in;
  lidx_t       lidx_in;
  logic [31:0] lvl_ext;
  logic [63:0] item_ext;

  // memories
  data_t       payload_mem [POOL_DEPTH];
  data_t       payload_rd_q;
  logic        payload_we;
  idx_t        link_raddr;
  idx_t        link_rd;
  link_wr_t    link_wr;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [ITEM_W-1:0] out_data_q, out_data_d;
  status_e           status_q, status_d;
  logic [LCOUNT_W-1:0] count_q, count_d;
  logic              any_q, any_d;
  logic [LEVEL_W-1:0] top_q, top_d;

  logic [63:0] odata_ext;
  logic [31:0] cnt_ext;
  cnt_t        size_cur;
  idx_t        head_cur, tail_cur;
  logic [SUM_W-1:0] cnt_sum;

  // --------------------------------------------------------------------------
  // Request decode and memory read addresses
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign lvl_ext   = 32'(level_i);
  assign lvl_ok_in = (lvl_ext < 32'(NUM_LEVELS));
  assign lidx_in   = lvl_ok_in ? lvl_ext[LIDX_W-1:0] : '0;
  assign item_ext  = 64'(item_data_i);

  // enqueue follows the free list; dequeue follows the level's head
  assign link_raddr = (action_e'(action_i) == ACT_ENQ) ? free_head_q : level_head_q[lidx_in];

  spmf_link_ram u_link_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (link_raddr),
    .rd_data_o (link_rd),
    .wr_i      (link_wr)
  );

  always_ff @(posedge clk_i) begin
    if (payload_we) begin
      payload_mem[free_head_q] <= data_q;
    end
    if (in_fire) begin
      payload_rd_q <= payload_mem[level_head_q[lidx_in]];
    end
  end

  // --------------------------------------------------------------------------
  // Update step: apply the action with the read data in hand
  // --------------------------------------------------------------------------
  assign size_cur = level_size_q[lidx_q];
  assign head_cur = level_head_q[lidx_q];
  assign tail_cur = level_tail_q[lidx_q];

  always_comb begin
    free_head_d  = free_head_q;
    free_count_d = free_count_q;
    level_size_d = level_size_q;
    level_head_d = level_head_q;
    level_tail_d = level_tail_q;
    link_wr      = '0;
    payload_we   = 1'b0;
    odata_ext    = '0;
    status_d     = ST_OK;

    if (!lvl_ok_q) begin
      status_d = ST_EMPTY;
    end else begin
      case (action_q)
        ACT_ENQ: begin
          if (free_count_q == '0) begin
            status_d = ST_FULL;
          end else begin
            // take the free head, append it at the tail
            payload_we   = exec_go;
            free_head_d  = link_rd;
            free_count_d = free_count_q - cnt_t'(1);
            if (size_cur == '0) begin
              level_head_d[lidx_q] = free_head_q;
            end else begin
              link_wr = '{en: exec_go, addr: tail_cur, data: free_head_q};
            end
            level_tail_d[lidx_q] = free_head_q;
            level_size_d[lidx_q] = size_cur + cnt_t'(1);
          end
        end
        ACT_DEQ: begin
          if (size_cur == '0) begin
            status_d = ST_EMPTY;
          end else begin
            // unlink the head, push it on the free list
            odata_ext            = 64'(payload_rd_q);
            level_head_d[lidx_q] = link_rd;
            level_size_d[lidx_q] = size_cur - cnt_t'(1);
            link_wr              = '{en: exec_go, addr: head_cur, data: free_head_q};
            free_head_d          = head_cur;
            free_count_d         = free_count_q + cnt_t'(1);
          end
        end
        ACT_PEEK: begin
          if (size_cur == '0) begin
            status_d = ST_EMPTY;
          end else begin
            odata_ext = 64'(payload_rd_q);
          end
        end
        default: begin
          // clear: splice the whole list onto the free list
          if (size_cur != '0) begin
            link_wr              = '{en: exec_go, addr: tail_cur, data: free_head_q};
            free_head_d          = head_cur;
            free_count_d         = free_count_q + size_cur;
            level_size_d[lidx_q] = '0;
          end
        end
      endcase
    end

    out_data_d = odata_ext[ITEM_W-1:0];
    cnt_ext    = lvl_ok_q ? 32'(level_size_d[lidx_q]) : '0;
    count_d    = cnt_ext[LCOUNT_W-1:0];

    // highest-priority nonempty level after the update
    any_d = 1'b0;
    top_d = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (level_size_d[i] != '0) begin
        any_d = 1'b1;
        top_d = LEVEL_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EXEC;
      S_EXEC:  if (exec_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (exec_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      free_head_q  <= '0;
      free_count_q <= cnt_t'(POOL_DEPTH);
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_size_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        free_head_q  <= free_head_d;
        free_count_q <= free_count_d;
        level_size_q <= level_size_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      action_q <= action_e'(action_i);
      lvl_ok_q <= lvl_ok_in;
      lidx_q   <= lidx_in;
      data_q   <= item_ext[DATA_WIDTH-1:0];
    end
    if (exec_go) begin
      level_head_q <= level_head_d;
      level_tail_q <= level_tail_d;
      out_data_q   <= out_data_d;
      status_q     <= status_d;
      count_q      <= count_d;
      any_q        <= any_d;
      top_q        <= top_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign status_o      = status_q;
  assign level_count_o = count_q;
  assign any_pending_o = any_q;
  assign top_level_o   = top_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_sum = SUM_W'(free_count_q);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_sum = cnt_sum + SUM_W'(level_size_q[i]);
    end
  end

  // every node is either free or owned by exactly one level
  a_node_conservation: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_sum == SUM_W'(POOL_DEPTH))
    else $error("pool node count lost");

  // an accepted request moves to its update step next cycle
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_EXEC)
    else $error("accepted request did not advance");

  // enqueue into an exhausted pool reports full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && lvl_ok_q && action_q == ACT_ENQ && free_count_q == '0)
      |=> status_q == ST_FULL && $stable(free_count_q))
    else $error("full pool enqueue not dropped");

  // no pending levels means top level reads zero
  a_top_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !any_q) |-> top_q == '0)
    else $error("top level set with nothing pending");

endmodule

// File: hdl/spmf_link_ram.sv
// ----------------------------------------------------------------------------
// spmf_link_ram
// Next-node link memory with a registered read. A valid bit per
// entry makes an unwritten entry read as its reset link, index plus one, the last wrapping to 0.
// ----------------------------------------------------------------------------
module spmf_link_ram
  import spmf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rd_en_i,
  input  idx_t     rd_addr_i,
  output idx_t     rd_data_o,
  input  link_wr_t wr_i
);

  idx_t                  mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] valid_q;
  idx_t                  rd_data_q;
  idx_t                  rd_addr_q;
  logic                  rd_valid_q;
  idx_t                  reset_link;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // entry i links to i+1, the last one wraps to 0
  assign reset_link = (rd_addr_q == idx_t'(POOL_DEPTH - 1)) ? '0 : rd_addr_q + idx_t'(1);
  assign rd_data_o  = rd_valid_q ? rd_data_q : reset_link;

endmodule

// File: dv/strict_priority_multi_fifo_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo_test
// Self-checking bench for the strict priority multi-queue. A queue of
// pending requests feeds a valid/ready driver. Each accepted item runs
// through a linked-pool model of the block, and the model's response goes
// into a scoreboard. A monitor with random back-pressure pops that
// scoreboard and compares every response field.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo_test;
  import spmf_pkg::*;

  localparam int NUM_PHASES = 17;
  localparam int PHASE_ITEMS = 100;

  typedef struct {
    action_e             action;
    logic [LEVEL_W-1:0]  level;
    logic [ITEM_W-1:0]   data;
  } req_t;

  typedef struct {
    logic [ITEM_W-1:0]   data;
    status_e             status;
    logic [LCOUNT_W-1:0] count;
    logic                any;
    logic [LEVEL_W-1:0]  top;
  } rsp_t;

  // clock, reset and block ports; every input starts at a known value
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i = '0;
  logic [LEVEL_W-1:0]  level_i = '0;
  logic [ITEM_W-1:0]   item_data_i = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  logic [ITEM_W-1:0]   out_data_o;
  logic [STATUS_W-1:0] status_o;
  logic [LCOUNT_W-1:0] level_count_o;
  logic                any_pending_o;
  logic [LEVEL_W-1:0]  top_level_o;

  // requests waiting to be driven, and responses the pool model predicts
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  req_t cur_req;

  // shadow copy of the node pool and the per-level lists
  data_t pool_data[POOL_DEPTH];
  idx_t  pool_next[POOL_DEPTH];
  idx_t  free_ptr;
  cnt_t  free_cnt;
  idx_t  head_ptr[NUM_LEVELS];
  idx_t  tail_ptr[NUM_LEVELS];
  cnt_t  lvl_cnt[NUM_LEVELS];

  // idle control shared by the driver and the monitor
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;
  int unsigned errors = 0;

  always #4 clk_i = ~clk_i;

  strict_priority_multi_fifo dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .level_i       (level_i),
    .item_data_i   (item_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .out_data_o    (out_data_o),
    .status_o      (status_o),
    .level_count_o (level_count_o),
    .any_pending_o (any_pending_o),
    .top_level_o   (top_level_o)
  );

  // Apply one request to the shadow pool and return the response it yields.
  function automatic rsp_t pool_response(req_t r);
    rsp_t o;
    idx_t n;
    int   lv;
    o.data = '0;
    o.status = ST_OK;
    o.count = '0;
    o.any = 1'b0;
    o.top = '0;
    lv = r.level;
    if (lv >= NUM_LEVELS) begin
      // level outside the configured set: nothing moves
      o.status = ST_EMPTY;
    end else begin
      case (r.action)
        ACT_ENQ: begin
          if (free_cnt == 0) begin
            o.status = ST_FULL;
          end else begin
            // pop the free list head and append it to the level
            n = free_ptr;
            free_ptr = pool_next[n];
            free_cnt--;
            pool_data[n] = r.data[DATA_WIDTH-1:0];
            if (lvl_cnt[lv] == 0) head_ptr[lv] = n;
            else pool_next[tail_ptr[lv]] = n;
            tail_ptr[lv] = n;
            lvl_cnt[lv]++;
          end
        end
        ACT_DEQ: begin
          if (lvl_cnt[lv] == 0) begin
            o.status = ST_EMPTY;
          end else begin
            // unlink the head and push it back onto the free list
            n = head_ptr[lv];
            o.data = ITEM_W'(pool_data[n]);
            head_ptr[lv] = pool_next[n];
            lvl_cnt[lv]--;
            pool_next[n] = free_ptr;
            free_ptr = n;
            free_cnt++;
          end
        end
        ACT_PEEK: begin
          if (lvl_cnt[lv] == 0) o.status = ST_EMPTY;
          else o.data = ITEM_W'(pool_data[head_ptr[lv]]);
        end
        default: begin
          // clear: splice the whole list in front of the free list
          if (lvl_cnt[lv] != 0) begin
            pool_next[tail_ptr[lv]] = free_ptr;
            free_ptr = head_ptr[lv];
            free_cnt += lvl_cnt[lv];
            lvl_cnt[lv] = '0;
          end
        end
      endcase
      o.count = LCOUNT_W'(lvl_cnt[lv]);
    end
    // lowest-numbered nonempty level wins
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (lvl_cnt[i] != 0) begin
        o.any = 1'b1;
        o.top = LEVEL_W'(i);
      end
    end
    return o;
  endfunction

  // Driver: hold the item until accepted, predict on acceptance, then load
  // the next one or idle for a short burst.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) expected_rsps.push_back(pool_response(cur_req));
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!quiet && pending_reqs.size() != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          action_i <= cur_req.action;
          level_i <= cur_req.level;
          item_data_i <= cur_req.data;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted response against the oldest prediction,
  // and stall the response channel in random bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response item with nothing expected: out_data %0h status %0d",
                 out_data_o, status_o);
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (out_data_o !== exp_rsp.data) begin
            $error("out_data: expected %0h actual %0h", exp_rsp.data, out_data_o);
            errors++;
          end
          if (status_o !== exp_rsp.status) begin
            $error("status: expected %0d actual %0d", exp_rsp.status, status_o);
            errors++;
          end
          if (level_count_o !== exp_rsp.count) begin
            $error("level_count: expected %0d actual %0d", exp_rsp.count, level_count_o);
            errors++;
          end
          if (any_pending_o !== exp_rsp.any) begin
            $error("any_pending: expected %0d actual %0d", exp_rsp.any, any_pending_o);
            errors++;
          end
          if (top_level_o !== exp_rsp.top) begin
            $error("top_level: expected %0d actual %0d", exp_rsp.top, top_level_o);
            errors++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_req(action_e a, int lv, logic [ITEM_W-1:0] d);
    req_t r;
    r.action = a;
    r.level = LEVEL_W'(lv);
    r.data = d;
    pending_reqs.push_back(r);
  endtask

  // Hold until every pending item is accepted and every response is back.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("strict_priority_multi_fifo: mismatch");
    $finish;
  end

  initial begin
    int      enq_w;
    int      deq_w;
    int      peek_w;
    int      lo;
    int      hi;
    int      lv;
    int      pick;
    action_e act;
    logic [ITEM_W-1:0] d;

    // reset image of the pool: all nodes free, linked in index order
    for (int i = 0; i < POOL_DEPTH; i++) begin
      pool_data[i] = '0;
      pool_next[i] = idx_t'((i + 1) % POOL_DEPTH);
    end
    free_ptr = '0;
    free_cnt = cnt_t'(POOL_DEPTH);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_ptr[i] = '0;
      tail_ptr[i] = '0;
      lvl_cnt[i] = '0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-level peek, dequeue and clear first, then both end
    // levels, both data extremes, clear of a live list and reuse of its nodes.
    idle_pct = 20;
    stall_pct = 20;
    queue_req(ACT_PEEK, 0, '0);
    queue_req(ACT_DEQ, 0, '0);
    queue_req(ACT_CLEAR, 0, '1);
    queue_req(ACT_ENQ, 7, '1);
    queue_req(ACT_ENQ, 0, '0);
    queue_req(ACT_ENQ, 0, 32'ha5a5_a5a5);
    queue_req(ACT_ENQ, 3, 32'h5a5a_5a5a);
    queue_req(ACT_PEEK, 0, '1);
    queue_req(ACT_DEQ, 0, '1);
    queue_req(ACT_PEEK, 0, '0);
    queue_req(ACT_DEQ, 7, '0);
    queue_req(ACT_DEQ, 7, '0);
    queue_req(ACT_PEEK, 7, '0);
    queue_req(ACT_CLEAR, 0, '0);
    queue_req(ACT_ENQ, 5, 32'h1234_5678);
    queue_req(ACT_ENQ, 5, 32'h8765_4321);
    queue_req(ACT_CLEAR, 3, '0);
    queue_req(ACT_PEEK, 5, '0);
    queue_req(ACT_CLEAR, 5, '0);
    queue_req(ACT_ENQ, 2, 32'h0000_0001);
    queue_req(ACT_DEQ, 2, '0);
    queue_req(ACT_CLEAR, 7, '0);

    // hold the sender off until the block has gone fully quiet
    wait_drained();

    // Random phases. The first one is enqueue-heavy so the pool runs dry;
    // later ones mix fill, drain and balanced traffic over a random band of
    // levels, which keeps lists deep and moves the top level around.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      while (pending_reqs.size() > 8) @(posedge clk_i);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      pick = (ph == 0) ? 0 : $urandom_range(0, 2);
      case (pick)
        0: begin enq_w = 90; deq_w = 5; peek_w = 5; end
        1: begin enq_w = 20; deq_w = 50; peek_w = 15; end
        default: begin enq_w = 40; deq_w = 30; peek_w = 20; end
      endcase
      // some phases run without any idling at all
      idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      lo = $urandom_range(0, NUM_LEVELS - 1);
      hi = $urandom_range(lo, NUM_LEVELS - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < enq_w) act = ACT_ENQ;
        else if (pick < enq_w + deq_w) act = ACT_DEQ;
        else if (pick < enq_w + deq_w + peek_w) act = ACT_PEEK;
        else act = ACT_CLEAR;
        lv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(lo, hi);
        case ($urandom_range(0, 15))
          0: d = '0;
          1: d = '1;
          default: d = $urandom;
        endcase
        queue_req(act, lv, d);
      end
      // a second full drain midway through the random traffic
      if (ph == NUM_PHASES / 2) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("strict_priority_multi_fifo: match");
    end else begin
      $display("strict_priority_multi_fifo: mismatch");
    end
    $finish;
  end

endmodule
